@@ design/dpmf_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the paged memory.
`timescale 1ns / 1ps
package dpmf_pkg;

  localparam int PAGE_BYTES = 8;
  localparam int OFF_W      = $clog2(PAGE_BYTES);
  localparam int NUM_PAGES  = 32;
  localparam int PG_W       = $clog2(NUM_PAGES);
  localparam int NUM_FRAMES = 8;
  localparam int FR_W       = $clog2(NUM_FRAMES);
  localparam int SWAP_SLOTS = 32;
  localparam int SL_W       = $clog2(SWAP_SLOTS);
  localparam int GRP_SIZE   = 8;
  localparam int GRP_W      = $clog2(GRP_SIZE);
  localparam int NUM_GRPS   = SWAP_SLOTS / GRP_SIZE;
  localparam int GRPN_W     = $clog2(NUM_GRPS);
  localparam int LOC_W      = 6;
  localparam int CNT_W      = OFF_W + 1;

  localparam logic [LOC_W-1:0] NO_PLACE  = 6'd63;
  localparam logic [7:0]       FILL_BYTE = 8'h30;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_LOAD  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_TEXT = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] SRC_SWAP = 2'd0;
  localparam logic [1:0] SRC_IMG  = 2'd1;
  localparam logic [1:0] SRC_FILL = 2'd2;

  localparam logic REG_TEXT = 1'b0;
  localparam logic REG_DATA = 1'b1;

  typedef struct packed {
    logic       cap;
    logic       img_wr;
    logic       res_load;
    logic [1:0] res_status;
    logic       res_rdata;
    logic       loc_sel_owner;
    logic       acc_rd;
    logic       acc_wr;
    logic       evict_clean;
    logic       scan_clr;
    logic       scan_inc;
    logic       slot_from_scan;
    logic       slot_from_loc;
    logic       src_load;
    logic [1:0] src;
    logic       copy_clr;
    logic       copy_out;
    logic       copy_in;
    logic       commit_out;
    logic       commit_in;
  } dpmf_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       text_hit;
    logic       pg_valid;
    logic       pg_dirty;
    logic       occupied;
    logic       owner_dirty;
    logic       grp_free;
    logic       grp_last;
    logic       copy_done;
    logic       swap_loc_ok;
    logic       in_image;
  } dpmf_sts_t;

endpackage

@@ design/demand_paged_memory_fifo.sv @@
// Top level of the demand-paged byte memory with round-robin frame replacement.
`timescale 1ns / 1ps
// Usage:
// A command beat is accepted at a rising edge where start is high and busy is
// low; in_command, in_address and in_write_data are sampled at that edge.
// Exactly one result follows per command: out_valid is high for one cycle with
// out_read_data and out_status, and the receiver cannot stall it.
// Configuration writes (cfg_index 0 = text size, 1 = data size) complete when
// cfg_valid and cfg_ready are high; cfg_ready is always high, and writes are
// expected only while the block is idle.
// Image loads, ignored commands and writes into text end after the lookup
// state; a write hit adds an access state, a read hit also a read-out state.
// A miss adds a victim check state, a fill source select state and a page
// fill; a dirty victim adds a swap bitmap scan of 8 slots per cycle plus a
// page copy-out; the byte memories move one byte per cycle. busy falls as
// the result is registered, so the next command can be accepted in the cycle
// the strobe is shown.
// Reset (synchronous, active low) empties the page table, frame owners and swap
// bitmap and clears the configuration directly, with no clearing pass.
module demand_paged_memory_fifo (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_command,
  input  logic [7:0] in_address,
  input  logic [7:0] in_write_data,
  output logic       out_valid,
  output logic [7:0] out_read_data,
  output logic [1:0] out_status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data
);

  dpmf_pkg::dpmf_cmd_t cmd;
  dpmf_pkg::dpmf_sts_t sts;

  // Registers are simple flops, so a configuration beat is always taken.
  assign cfg_ready = 1'b1;

  dpmf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  dpmf_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_command    (in_command),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .cfg_wr        (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_status    (out_status)
  );

endmodule

@@ design/dpmf_ctrl.sv @@
// Controller state machine sequencing lookups, evictions, page copies and results.
`timescale 1ns / 1ps
module dpmf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dpmf_pkg::dpmf_sts_t sts,
  output dpmf_pkg::dpmf_cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHECK   = 4'd1;
  localparam logic [3:0] S_EVAL    = 4'd2;
  localparam logic [3:0] S_SCAN    = 4'd3;
  localparam logic [3:0] S_COPYOUT = 4'd4;
  localparam logic [3:0] S_FILLSEL = 4'd5;
  localparam logic [3:0] S_COPYIN  = 4'd6;
  localparam logic [3:0] S_ACCESS  = 4'd7;
  localparam logic [3:0] S_RDOUT   = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.cap   = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.cmd == dpmf_pkg::CMD_LOAD) begin
          cmd.img_wr   = 1'b1;
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end else if (sts.cmd != dpmf_pkg::CMD_READ && sts.cmd != dpmf_pkg::CMD_WRITE) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end else if (sts.cmd == dpmf_pkg::CMD_WRITE && sts.text_hit) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = dpmf_pkg::ST_TEXT;
          state_nxt      = S_IDLE;
        end else if (sts.pg_valid) begin
          state_nxt = S_ACCESS;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.loc_sel_owner = 1'b1;
        if (sts.occupied && sts.owner_dirty) begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_SCAN;
        end else begin
          cmd.evict_clean = sts.occupied;
          state_nxt       = S_FILLSEL;
        end
      end
      S_SCAN: begin
        if (sts.grp_free) begin
          cmd.slot_from_scan = 1'b1;
          cmd.copy_clr       = 1'b1;
          state_nxt          = S_COPYOUT;
        end else if (sts.grp_last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = dpmf_pkg::ST_FULL;
          state_nxt      = S_IDLE;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_COPYOUT: begin
        cmd.copy_out      = 1'b1;
        cmd.loc_sel_owner = 1'b1;
        if (sts.copy_done) begin
          cmd.commit_out = 1'b1;
          state_nxt      = S_FILLSEL;
        end
      end
      S_FILLSEL: begin
        cmd.src_load = 1'b1;
        cmd.copy_clr = 1'b1;
        if (sts.pg_dirty && sts.swap_loc_ok) begin
          cmd.src           = dpmf_pkg::SRC_SWAP;
          cmd.slot_from_loc = 1'b1;
        end else if (!sts.pg_dirty && sts.in_image) begin
          cmd.src = dpmf_pkg::SRC_IMG;
        end else begin
          cmd.src = dpmf_pkg::SRC_FILL;
        end
        state_nxt = S_COPYIN;
      end
      S_COPYIN: begin
        cmd.copy_in = 1'b1;
        if (sts.copy_done) begin
          cmd.commit_in = 1'b1;
          state_nxt     = S_ACCESS;
        end
      end
      S_ACCESS: begin
        if (sts.cmd == dpmf_pkg::CMD_READ) begin
          cmd.acc_rd = 1'b1;
          state_nxt  = S_RDOUT;
        end else begin
          cmd.acc_wr   = 1'b1;
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RDOUT: begin
        cmd.res_load  = 1'b1;
        cmd.res_rdata = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/dpmf_dp.sv @@
// Datapath: page table, frame owners, swap bitmap, byte memories, copy engine, result register.
`timescale 1ns / 1ps
module dpmf_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          in_command,
  input  logic [7:0]          in_address,
  input  logic [7:0]          in_write_data,
  input  logic                cfg_wr,
  input  logic                cfg_index,
  input  logic [8:0]          cfg_data,
  input  dpmf_pkg::dpmf_cmd_t cmd,
  output dpmf_pkg::dpmf_sts_t sts,
  output logic                out_valid,
  output logic [7:0]          out_read_data,
  output logic [1:0]          out_status
);

  localparam int PHYS_W = dpmf_pkg::FR_W + dpmf_pkg::OFF_W;
  localparam int SWAPA_W = dpmf_pkg::SL_W + dpmf_pkg::OFF_W;

  logic [8:0] text_r, data_r;
  logic [1:0] cmd_r;
  logic [7:0] addr_r, wdata_r;

  logic [dpmf_pkg::NUM_PAGES-1:0]  valid_r, dirty_r;
  logic [dpmf_pkg::LOC_W-1:0]      loc_r   [dpmf_pkg::NUM_PAGES];
  logic [dpmf_pkg::LOC_W-1:0]      owner_r [dpmf_pkg::NUM_FRAMES];
  logic [dpmf_pkg::FR_W-1:0]       vp_r;
  logic [dpmf_pkg::SWAP_SLOTS-1:0] used_r;
  logic [dpmf_pkg::GRPN_W-1:0]     scan_r;
  logic [dpmf_pkg::SL_W-1:0]       slot_r;
  logic [1:0]                      src_r;
  logic [dpmf_pkg::CNT_W-1:0]      cnt_r;

  logic [7:0] phys_mem [2**PHYS_W];
  logic [7:0] swap_mem [2**SWAPA_W];
  logic [7:0] img_mem  [256];
  logic [7:0] phys_q, swap_q, img_q;

  logic                       out_valid_r;
  logic [7:0]                 out_rd_r;
  logic [1:0]                 out_st_r;

  logic [dpmf_pkg::PG_W-1:0]  pg, owner_idx, loc_idx;
  logic [dpmf_pkg::OFF_W-1:0] off, cidx, widx;
  logic [dpmf_pkg::LOC_W-1:0] owner, loc_rd;
  logic [7:0]                 grp;
  logic [dpmf_pkg::GRP_W-1:0] pe;
  logic                       pe_hit;
  logic                       rd_go, wr_go;
  logic [7:0]                 fill_data;
  logic [9:0]                 img_limit;

  assign pg        = addr_r[7 -: dpmf_pkg::PG_W];
  assign off       = addr_r[dpmf_pkg::OFF_W-1:0];
  assign owner     = owner_r[vp_r];
  assign owner_idx = owner[dpmf_pkg::PG_W-1:0];
  assign loc_idx   = cmd.loc_sel_owner ? owner_idx : pg;
  assign loc_rd    = loc_r[loc_idx];
  assign cidx      = cnt_r[dpmf_pkg::OFF_W-1:0];
  assign widx      = cidx - 1'b1;
  assign rd_go     = !cnt_r[dpmf_pkg::OFF_W];
  assign wr_go     = (cnt_r != '0);
  assign grp       = used_r[scan_r*dpmf_pkg::GRP_SIZE +: dpmf_pkg::GRP_SIZE];
  assign img_limit = {1'b0, text_r} + {1'b0, data_r};

  // Lowest free slot within the current group of the swap bitmap.
  always_comb begin
    pe     = '0;
    pe_hit = 1'b0;
    for (int i = dpmf_pkg::GRP_SIZE - 1; i >= 0; i--) begin
      if (!grp[i]) begin
        pe     = dpmf_pkg::GRP_W'(i);
        pe_hit = 1'b1;
      end
    end
  end

  always_comb begin
    case (src_r)
      dpmf_pkg::SRC_SWAP: fill_data = swap_q;
      dpmf_pkg::SRC_IMG:  fill_data = img_q;
      default:            fill_data = dpmf_pkg::FILL_BYTE;
    endcase
  end

  always_comb begin
    sts.cmd         = cmd_r;
    sts.text_hit    = ({1'b0, addr_r} < text_r);
    sts.pg_valid    = valid_r[pg];
    sts.pg_dirty    = dirty_r[pg];
    sts.occupied    = (owner < dpmf_pkg::LOC_W'(dpmf_pkg::NUM_PAGES)) && valid_r[owner_idx]
                      && (loc_rd == dpmf_pkg::LOC_W'(vp_r));
    sts.owner_dirty = dirty_r[owner_idx];
    sts.grp_free    = pe_hit;
    sts.grp_last    = (scan_r == dpmf_pkg::GRPN_W'(dpmf_pkg::NUM_GRPS - 1));
    sts.copy_done   = (cnt_r == dpmf_pkg::CNT_W'(dpmf_pkg::PAGE_BYTES));
    sts.swap_loc_ok = (loc_rd < dpmf_pkg::LOC_W'(dpmf_pkg::SWAP_SLOTS));
    sts.in_image    = ({2'b00, addr_r} < img_limit);
  end

  // Control state of the page table and replacement logic.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_r      <= '0;
      data_r      <= '0;
      valid_r     <= '0;
      dirty_r     <= '0;
      used_r      <= '0;
      vp_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < dpmf_pkg::NUM_PAGES; i++) loc_r[i] <= dpmf_pkg::NO_PLACE;
      for (int i = 0; i < dpmf_pkg::NUM_FRAMES; i++) owner_r[i] <= dpmf_pkg::NO_PLACE;
    end else begin
      if (cfg_wr && cfg_index == dpmf_pkg::REG_TEXT) text_r <= cfg_data;
      if (cfg_wr && cfg_index == dpmf_pkg::REG_DATA) data_r <= cfg_data;
      out_valid_r <= cmd.res_load;
      if (cmd.evict_clean) begin
        valid_r[owner_idx] <= 1'b0;
        loc_r[owner_idx]   <= dpmf_pkg::NO_PLACE;
      end
      if (cmd.commit_out) begin
        valid_r[owner_idx] <= 1'b0;
        loc_r[owner_idx]   <= dpmf_pkg::LOC_W'(slot_r);
        used_r[slot_r]     <= 1'b1;
      end
      if (cmd.commit_in) begin
        if (src_r == dpmf_pkg::SRC_SWAP) used_r[slot_r] <= 1'b0;
        valid_r[pg]   <= 1'b1;
        loc_r[pg]     <= dpmf_pkg::LOC_W'(vp_r);
        owner_r[vp_r] <= dpmf_pkg::LOC_W'(pg);
        vp_r          <= vp_r + 1'b1;
      end
      if (cmd.acc_wr) dirty_r[pg] <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cmd_r   <= in_command;
      addr_r  <= in_address;
      wdata_r <= in_write_data;
    end
    if (cmd.scan_clr) scan_r <= '0;
    else if (cmd.scan_inc) scan_r <= scan_r + 1'b1;
    if (cmd.slot_from_scan) slot_r <= {scan_r, pe};
    else if (cmd.slot_from_loc) slot_r <= loc_rd[dpmf_pkg::SL_W-1:0];
    if (cmd.src_load) src_r <= cmd.src;
    if (cmd.copy_clr) cnt_r <= '0;
    else if (cmd.copy_out || cmd.copy_in) cnt_r <= cnt_r + 1'b1;
    if (cmd.res_load) begin
      out_st_r <= cmd.res_status;
      out_rd_r <= cmd.res_rdata ? phys_q : 8'h00;
    end
  end

  // Physical frame memory: one read and one write port.
  always_ff @(posedge clk) begin
    if (cmd.copy_out && rd_go) phys_q <= phys_mem[{vp_r, cidx}];
    else if (cmd.acc_rd) phys_q <= phys_mem[{loc_rd[dpmf_pkg::FR_W-1:0], off}];
    if (cmd.copy_in && wr_go) phys_mem[{vp_r, widx}] <= fill_data;
    else if (cmd.acc_wr) phys_mem[{loc_rd[dpmf_pkg::FR_W-1:0], off}] <= wdata_r;
  end

  // Swap memory.
  always_ff @(posedge clk) begin
    if (cmd.copy_in && rd_go) swap_q <= swap_mem[{slot_r, cidx}];
    if (cmd.copy_out && wr_go) swap_mem[{slot_r, widx}] <= phys_q;
  end

  // Program image memory.
  always_ff @(posedge clk) begin
    if (cmd.copy_in && rd_go) img_q <= img_mem[{pg, cidx}];
    if (cmd.img_wr) img_mem[addr_r] <= wdata_r;
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_rd_r;
  assign out_status    = out_st_r;

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the demand-paged byte memory with round-robin frame replacement.
`timescale 1ns / 1ps
module tb_top;

  // Command code 3 has no meaning to the block; it must be ignored.
  localparam logic [1:0] CMD_IGNORED = 2'd3;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_command;
  logic [7:0] in_address;
  logic [7:0] in_write_data;
  logic       out_valid;
  logic [7:0] out_read_data;
  logic [1:0] out_status;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [8:0] cfg_data;

  demand_paged_memory_fifo dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_address   (in_address),
    .in_write_data(in_write_data),
    .out_valid    (out_valid),
    .out_read_data(out_read_data),
    .out_status   (out_status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // A 4 ns clock, low and high for 2 ns each.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Expected result of one command beat.
  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] status;
  } mem_result_t;

  mem_result_t pending_results[$];
  int          mismatch_count;

  // Shadow copy of the memory system. The image is fully loaded before any
  // configuration lets a miss read from it, so its reset value never matters.
  bit         shadow_valid[dpmf_pkg::NUM_PAGES];
  bit         shadow_dirty[dpmf_pkg::NUM_PAGES];
  int         shadow_location[dpmf_pkg::NUM_PAGES];
  int         shadow_owner[dpmf_pkg::NUM_FRAMES];
  int         shadow_pointer;
  logic [7:0] shadow_phys[dpmf_pkg::NUM_FRAMES*dpmf_pkg::PAGE_BYTES];
  logic [7:0] shadow_swap[dpmf_pkg::SWAP_SLOTS*dpmf_pkg::PAGE_BYTES];
  bit         shadow_slot_used[dpmf_pkg::SWAP_SLOTS];
  logic [7:0] shadow_image[256];
  int         text_len;
  int         data_len;

  function automatic void shadow_reset();
    for (int i = 0; i < dpmf_pkg::NUM_PAGES; i++) begin
      shadow_valid[i] = 0;
      shadow_dirty[i] = 0;
      shadow_location[i] = dpmf_pkg::NO_PLACE;
    end
    for (int i = 0; i < dpmf_pkg::NUM_FRAMES; i++) shadow_owner[i] = dpmf_pkg::NO_PLACE;
    for (int i = 0; i < dpmf_pkg::NUM_FRAMES*dpmf_pkg::PAGE_BYTES; i++)
      shadow_phys[i] = dpmf_pkg::FILL_BYTE;
    for (int i = 0; i < dpmf_pkg::SWAP_SLOTS*dpmf_pkg::PAGE_BYTES; i++)
      shadow_swap[i] = dpmf_pkg::FILL_BYTE;
    for (int i = 0; i < dpmf_pkg::SWAP_SLOTS; i++) shadow_slot_used[i] = 0;
    for (int i = 0; i < 256; i++) shadow_image[i] = 8'h00;
    shadow_pointer = 0;
    text_len = 0;
    data_len = 0;
  endfunction

  // Brings a page into the frame at the victim pointer. Returns 0 when a
  // dirty victim cannot find a free swap slot; then nothing changes.
  function automatic bit fault_in_page(int pg, int addr);
    int f;
    int owner;
    int slot;
    f = shadow_pointer % dpmf_pkg::NUM_FRAMES;
    owner = shadow_owner[f];
    if (owner < dpmf_pkg::NUM_PAGES && shadow_valid[owner] && shadow_location[owner] == f) begin
      if (shadow_dirty[owner]) begin
        slot = dpmf_pkg::SWAP_SLOTS;
        for (int i = dpmf_pkg::SWAP_SLOTS - 1; i >= 0; i--)
          if (!shadow_slot_used[i]) slot = i;
        if (slot >= dpmf_pkg::SWAP_SLOTS) return 0;
        for (int i = 0; i < dpmf_pkg::PAGE_BYTES; i++)
          shadow_swap[slot*dpmf_pkg::PAGE_BYTES+i] = shadow_phys[f*dpmf_pkg::PAGE_BYTES+i];
        shadow_slot_used[slot] = 1;
        shadow_location[owner] = slot;
      end else begin
        shadow_location[owner] = dpmf_pkg::NO_PLACE;
      end
      shadow_valid[owner] = 0;
    end
    if (shadow_dirty[pg]) begin
      slot = shadow_location[pg];
      if (slot < dpmf_pkg::SWAP_SLOTS) begin
        for (int i = 0; i < dpmf_pkg::PAGE_BYTES; i++) begin
          shadow_phys[f*dpmf_pkg::PAGE_BYTES+i] = shadow_swap[slot*dpmf_pkg::PAGE_BYTES+i];
          shadow_swap[slot*dpmf_pkg::PAGE_BYTES+i] = dpmf_pkg::FILL_BYTE;
        end
        shadow_slot_used[slot] = 0;
      end else begin
        for (int i = 0; i < dpmf_pkg::PAGE_BYTES; i++)
          shadow_phys[f*dpmf_pkg::PAGE_BYTES+i] = dpmf_pkg::FILL_BYTE;
      end
    end else if (addr < text_len + data_len) begin
      for (int i = 0; i < dpmf_pkg::PAGE_BYTES; i++)
        shadow_phys[f*dpmf_pkg::PAGE_BYTES+i] =
          shadow_image[(pg*dpmf_pkg::PAGE_BYTES+i) & 255];
    end else begin
      for (int i = 0; i < dpmf_pkg::PAGE_BYTES; i++)
        shadow_phys[f*dpmf_pkg::PAGE_BYTES+i] = dpmf_pkg::FILL_BYTE;
    end
    shadow_valid[pg] = 1;
    shadow_location[pg] = f;
    shadow_owner[f] = pg;
    shadow_pointer = (f + 1) % dpmf_pkg::NUM_FRAMES;
    return 1;
  endfunction

  // Computes the result of one command and updates the shadow state.
  function automatic mem_result_t predict_access(logic [1:0] cmd, logic [7:0] addr,
                                                 logic [7:0] wdata);
    mem_result_t r;
    int pg;
    int idx;
    r.read_data = 8'h00;
    r.status = dpmf_pkg::ST_OK;
    pg = (addr / dpmf_pkg::PAGE_BYTES) % dpmf_pkg::NUM_PAGES;
    if (cmd == dpmf_pkg::CMD_LOAD) begin
      shadow_image[addr] = wdata;
    end else if (cmd == dpmf_pkg::CMD_READ || cmd == dpmf_pkg::CMD_WRITE) begin
      if (cmd == dpmf_pkg::CMD_WRITE && addr < text_len) begin
        r.status = dpmf_pkg::ST_TEXT;
      end else if (!shadow_valid[pg] && !fault_in_page(pg, addr)) begin
        r.status = dpmf_pkg::ST_FULL;
      end else begin
        idx = (shadow_location[pg] % dpmf_pkg::NUM_FRAMES) * dpmf_pkg::PAGE_BYTES
              + addr % dpmf_pkg::PAGE_BYTES;
        if (cmd == dpmf_pkg::CMD_READ) begin
          r.read_data = shadow_phys[idx];
        end else begin
          shadow_dirty[pg] = 1;
          shadow_phys[idx] = wdata;
        end
      end
    end
    return r;
  endfunction

  // Sends one command beat and leaves start high, so that a following beat
  // in the same burst needs no second assignment in the same time step.
  task automatic send_command(logic [1:0] cmd, logic [7:0] addr, logic [7:0] wdata);
    start <= 1'b1;
    in_command <= cmd;
    in_address <= addr;
    in_write_data <= wdata;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_access(cmd, addr, wdata));
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Lowers start and waits until every expected result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Writes both size registers while the block is idle.
  task automatic program_sizes(int text_val, int data_val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= dpmf_pkg::REG_TEXT;
    cfg_data <= text_val[8:0];
    do @(posedge clk); while (!cfg_ready);
    text_len = text_val;
    cfg_index <= dpmf_pkg::REG_DATA;
    cfg_data <= data_val[8:0];
    do @(posedge clk); while (!cfg_ready);
    data_len = data_val;
    cfg_valid <= 1'b0;
  endtask

  // Plain reads and writes with an empty program image region: 0x30 fill,
  // address extremes, the ignored command, an image load, and a dirty page
  // that is evicted to swap and later faulted back in.
  task automatic test_basic_access();
    send_command(dpmf_pkg::CMD_READ, 8'h00, 8'h00);
    send_command(dpmf_pkg::CMD_WRITE, 8'h00, 8'hFF);
    send_command(dpmf_pkg::CMD_READ, 8'h00, 8'h00);
    send_command(dpmf_pkg::CMD_WRITE, 8'hFF, 8'h00);
    send_command(dpmf_pkg::CMD_READ, 8'hFF, 8'hFF);
    send_command(CMD_IGNORED, 8'hAA, 8'h55);
    send_command(dpmf_pkg::CMD_LOAD, 8'h00, 8'hA5);
    // Touch nine more pages so that page 0 and others are pushed out.
    for (int p = 1; p <= 9; p++)
      send_command(dpmf_pkg::CMD_WRITE, 8'(p*dpmf_pkg::PAGE_BYTES + p % 8), 8'(p));
    send_command(dpmf_pkg::CMD_READ, 8'h00, 8'h00);
    send_command(dpmf_pkg::CMD_READ, 8'hFF, 8'h00);
    send_command(dpmf_pkg::CMD_READ, 8'h09, 8'h00);
  endtask

  // Loads every image byte so that later misses may read any of them.
  task automatic test_image_load();
    for (int a = 0; a < 256; a++) begin
      send_command(dpmf_pkg::CMD_LOAD, 8'(a), 8'($urandom));
      if ($urandom_range(0, 9) == 0) pause_sender($urandom_range(1, 6));
    end
  endtask

  // Writes inside the text region are refused; pages below text plus data
  // come from the image.
  task automatic test_text_protect();
    program_sizes(16, 16);
    send_command(dpmf_pkg::CMD_WRITE, 8'h00, 8'h12);
    send_command(dpmf_pkg::CMD_WRITE, 8'h0F, 8'h34);
    send_command(dpmf_pkg::CMD_WRITE, 8'h10, 8'h56);
    send_command(dpmf_pkg::CMD_READ, 8'h10, 8'h00);
    send_command(dpmf_pkg::CMD_READ, 8'h1F, 8'h00);
    send_command(dpmf_pkg::CMD_READ, 8'h20, 8'h00);
  endtask

  // Random traffic in bursts with random gaps. Addresses are mostly kept to
  // a window of more pages than there are frames so that hits, clean and dirty
  // evictions and swap refills are all frequent.
  task automatic random_phase(int count, int window_pages);
    logic [1:0] cmd;
    logic [7:0] addr;
    int burst;
    int pick;
    int base;
    base = $urandom_range(0, dpmf_pkg::NUM_PAGES - 1);
    burst = $urandom_range(1, 20);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) cmd = dpmf_pkg::CMD_READ;
      else if (pick < 85) cmd = dpmf_pkg::CMD_WRITE;
      else if (pick < 95) cmd = dpmf_pkg::CMD_LOAD;
      else cmd = CMD_IGNORED;
      if ($urandom_range(0, 4) == 0)
        addr = 8'($urandom);
      else
        addr = 8'((((base + $urandom_range(0, window_pages - 1)) % dpmf_pkg::NUM_PAGES)
                   * dpmf_pkg::PAGE_BYTES) + $urandom_range(0, dpmf_pkg::PAGE_BYTES - 1));
      send_command(cmd, addr, 8'($urandom));
      burst--;
      if (burst == 0) begin
        // Some bursts run straight into the next one with no gap.
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 15));
        burst = $urandom_range(1, 20);
      end
    end
  endtask

  // Several size settings, the extremes among them, each with random traffic.
  task automatic test_random_traffic();
    program_sizes(256, 256);
    random_phase(90, 12);
    program_sizes(0, 0);
    random_phase(110, 12);
    program_sizes(0, 256);
    random_phase(110, 16);
    program_sizes($urandom_range(0, 256), $urandom_range(0, 256));
    random_phase(110, 24);
  endtask

  // Each result is held for one cycle and taken at the edge that ends it.
  always @(posedge clk) begin
    mem_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: read_data=%02h status=%0d",
                   out_read_data, out_status);
      end else begin
        want = pending_results.pop_front();
        if (out_read_data !== want.read_data || out_status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected read_data=%02h status=%0d, got %02h %0d",
                     want.read_data, want.status, out_read_data, out_status);
        end
      end
    end
  end

  initial begin
    mismatch_count = 0;
    shadow_reset();
    rst_n = 1'b0;
    start = 1'b0;
    in_command = dpmf_pkg::CMD_READ;
    in_address = 8'h00;
    in_write_data = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = dpmf_pkg::REG_TEXT;
    cfg_data = 9'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_access();
    test_image_load();
    test_text_protect();
    // The sender holds off here until the block has nothing outstanding.
    wait_drained();
    test_random_traffic();

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
